/* rtl/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg
// Types, codes and the power sequence step table of the panel power sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

    // Input action codes
    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_LEVEL = 2'd1;
    localparam logic [1:0] ACT_MODE  = 2'd2;

    // Blank modes of interest
    localparam logic [2:0] MODE_UNBLANK   = 3'd0;
    localparam logic [2:0] MODE_POWERDOWN = 3'd4;
    localparam logic [2:0] MODE_LAST      = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_BAD_PINS = 2'd1;
    localparam logic [1:0] STAT_BUSY     = 2'd2;

    // Configuration register indexes
    localparam logic CFG_PIN_COUNT = 1'b0;
    localparam logic CFG_PWM_BASE  = 1'b1;

    // Configuration reset values
    localparam logic [2:0]  PIN_COUNT_RESET = 3'd4;
    localparam logic [31:0] PWM_BASE_RESET  = 32'h0002_8420;

    // Brightness limit and duty width
    localparam logic [3:0] MAX_LEVEL  = 4'd10;
    localparam int         DUTY_W     = 5;

    // Sequenced pin count bounds
    localparam logic [2:0] PINS_MIN = 3'd2;
    localparam logic [2:0] PINS_MAX = 3'd4;

    // Latched pin count codes (count minus two)
    localparam logic [1:0] SEQ_2PIN = 2'd0;
    localparam logic [1:0] SEQ_3PIN = 2'd1;
    localparam logic [1:0] SEQ_4PIN = 2'd2;

    // Pin bits
    localparam logic [3:0] PIN_LCD  = 4'b0001;
    localparam logic [3:0] PIN_VDD  = 4'b0010;
    localparam logic [3:0] PIN_BIAS = 4'b0100;
    localparam logic [3:0] PIN_BL   = 4'b1000;

    // Delays in millisecond ticks
    localparam logic [7:0] DLY_10  = 8'd10;
    localparam logic [7:0] DLY_20  = 8'd20;
    localparam logic [7:0] DLY_25  = 8'd25;
    localparam logic [7:0] DLY_50  = 8'd50;
    localparam logic [7:0] DLY_250 = 8'd250;
    localparam logic [7:0] DLY_END = 8'd0;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] brightness;
        logic [2:0] blank_mode;
    } item_t;

    typedef struct packed {
        logic [31:0] pwm_word;
        logic        lcd_enable;
        logic        vdd_enable;
        logic        bias_enable;
        logic        backlight_enable;
        logic        busy_res;
        logic [3:0]  brightness_now;
        logic [1:0]  status;
    } result_t;

    // Sequencer state
    typedef struct packed {
        logic [2:0]        power_mode;
        logic [3:0]        level;
        logic [DUTY_W-1:0] duty;
        logic [3:0]        pin_levels;
        logic [2:0]        seq_step;
        logic              seq_turning_on;
        logic              seq_running;
        logic [7:0]        delay_left;
        logic [1:0]        seq_pins;
    } pps_state_t;

    // One step of a sequence: pins touched, then delay before the next step
    typedef struct packed {
        logic [3:0] mask;
        logic [7:0] delay;
    } step_t;

    function automatic step_t step_lookup(logic [1:0] pins, logic on, logic [1:0] idx);
        step_t r;
        r.mask  = '0;
        r.delay = DLY_END;
        case (pins)
            SEQ_2PIN:
            begin
                if (on)
                begin
                    case (idx)
                        2'd0:    r = '{mask: PIN_LCD, delay: DLY_25};
                        2'd1:    r = '{mask: PIN_BL,  delay: DLY_END};
                        default: r = '{mask: 4'b0000, delay: DLY_END};
                    endcase
                end
                else
                begin
                    case (idx)
                        2'd0:    r = '{mask: PIN_BL,  delay: DLY_250};
                        2'd1:    r = '{mask: PIN_LCD, delay: DLY_END};
                        default: r = '{mask: 4'b0000, delay: DLY_END};
                    endcase
                end
            end
            SEQ_3PIN:
            begin
                if (on)
                begin
                    case (idx)
                        2'd0:    r = '{mask: PIN_LCD, delay: DLY_25};
                        2'd1:    r = '{mask: PIN_VDD, delay: DLY_250};
                        2'd2:    r = '{mask: PIN_BL,  delay: DLY_END};
                        default: r = '{mask: 4'b0000, delay: DLY_END};
                    endcase
                end
                else
                begin
                    case (idx)
                        2'd0:    r = '{mask: PIN_BL,  delay: DLY_250};
                        2'd1:    r = '{mask: PIN_VDD, delay: DLY_25};
                        2'd2:    r = '{mask: PIN_LCD, delay: DLY_END};
                        default: r = '{mask: 4'b0000, delay: DLY_END};
                    endcase
                end
            end
            default:
            begin
                // four pins; an out-of-range latched count behaves the same
                if (on)
                begin
                    case (idx)
                        2'd0:    r = '{mask: PIN_LCD,  delay: DLY_50};
                        2'd1:    r = '{mask: PIN_VDD,  delay: DLY_20};
                        2'd2:    r = '{mask: PIN_BIAS, delay: DLY_250};
                        default: r = '{mask: PIN_BL,   delay: DLY_END};
                    endcase
                end
                else
                begin
                    case (idx)
                        2'd0:    r = '{mask: PIN_BL, delay: DLY_25};
                        2'd1:    r = '{mask: PIN_LCD | PIN_BIAS | PIN_VDD, delay: DLY_END};
                        default: r = '{mask: 4'b0000, delay: DLY_END};
                    endcase
                end
            end
        endcase
        return r;
    endfunction

    // Duty for a brightness level: level * 3 kept to five bits
    function automatic logic [DUTY_W-1:0] duty_of(logic [3:0] lvl);
        logic [5:0] prod;
        prod = {1'b0, lvl, 1'b0} + {2'b00, lvl};
        return prod[DUTY_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/pps_step.sv */
// ----------------------------------------------------------------------------
// pps_step
// Next-state and result logic for one tick, brightness or blank-mode item.
// ----------------------------------------------------------------------------
`default_nettype none

module pps_step
    import pps_pkg::*;
(
    input  wire pps_state_t  st,
    input  wire item_t       item,
    input  wire logic [2:0]  pin_count,
    input  wire logic [31:0] pwm_base,
    output pps_state_t       st_next,
    output result_t          res
);

    pps_state_t  n;
    logic [1:0]  stat;
    logic        do_apply;
    logic [3:0]  req;
    logic [7:0]  dec;
    step_t       stp;

    // Item decode and state update
    always_comb
    begin
        n        = st;
        stat     = STAT_OK;
        do_apply = 1'b0;
        req      = (item.brightness > MAX_LEVEL) ? MAX_LEVEL : item.brightness;
        dec      = (st.delay_left != 8'd0) ? (st.delay_left - 8'd1) : 8'd0;
        stp      = '0;

        case (item.action)
            ACT_TICK:
            begin
                if (st.seq_running)
                begin
                    n.delay_left = dec;
                    do_apply     = (dec == 8'd0);
                end
            end
            ACT_LEVEL:
            begin
                if (req != st.level)
                begin
                    if (st.power_mode == MODE_UNBLANK)
                    begin
                        n.duty = duty_of(req);
                    end
                    n.level = req;
                end
            end
            ACT_MODE:
            begin
                if (st.seq_running)
                begin
                    stat = STAT_BUSY;
                end
                else if (item.blank_mode <= MODE_LAST && item.blank_mode != st.power_mode)
                begin
                    n.power_mode = item.blank_mode;
                    n.duty = (item.blank_mode == MODE_UNBLANK) ? duty_of(st.level) : '0;
                    if (pin_count inside {[PINS_MIN:PINS_MAX]})
                    begin
                        n.seq_pins       = 2'(pin_count - PINS_MIN);
                        n.seq_turning_on = (item.blank_mode == MODE_UNBLANK);
                        n.seq_step       = 3'd0;
                        n.seq_running    = 1'b1;
                        do_apply         = 1'b1;
                    end
                    else
                    begin
                        stat = STAT_BAD_PINS;
                    end
                end
            end
            default:
            begin
                // unused action code: no change
            end
        endcase

        // One step of the pin sequence
        if (do_apply)
        begin
            stp = step_lookup(n.seq_pins, n.seq_turning_on, n.seq_step[1:0]);
            if (n.seq_turning_on)
            begin
                n.pin_levels = n.pin_levels | stp.mask;
            end
            else
            begin
                n.pin_levels = n.pin_levels & ~stp.mask;
            end
            n.delay_left = stp.delay;
            n.seq_step   = {1'b0, n.seq_step[1:0]} + 3'd1;
            if (stp.delay == DLY_END)
            begin
                n.seq_running = 1'b0;
            end
        end
    end

    assign st_next = n;

    // Result fields
    always_comb
    begin
        res.pwm_word         = {pwm_base[31:DUTY_W], n.duty};
        res.lcd_enable       = n.pin_levels[0];
        res.vdd_enable       = n.pin_levels[1];
        res.bias_enable      = n.pin_levels[2];
        res.backlight_enable = n.pin_levels[3];
        res.busy_res         = n.seq_running;
        res.brightness_now   = n.level;
        res.status           = stat;
    end

endmodule

`default_nettype wire

/* rtl/panel_power_sequencer.sv */
// ----------------------------------------------------------------------------
// panel_power_sequencer
// LCD panel power and backlight control: PWM duty word and timed pin sequence.
// ----------------------------------------------------------------------------
//   Channel  Handshake              Payload
//   req      req_valid / req_stall  req_data  (action, brightness, blank_mode)
//   rsp      rsp_valid / rsp_stall  rsp_data  (pwm word, pins, busy, level, status)
//   cfg      cfg_we                 cfg_index, cfg_data
//
// One item per cycle unless the output stalls; each transfer gives one registered result.
// An input register holds the accepted item; the state update and the result
// are formed between it and the output register.
// A stalled output holds its result while one more item waits in the input
// register; after that req_stall rises.
// Reset clears the handshake state and restores the sequencer and config.
// ----------------------------------------------------------------------------
`default_nettype none

module panel_power_sequencer
    import pps_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire item_t       req_data,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output result_t          rsp_data,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic        hold_valid_reg;
    logic        hold_valid_next;
    item_t       hold_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;
    pps_state_t  state_reg;
    pps_state_t  state_next;
    result_t     res;
    logic [2:0]  pin_count_reg;
    logic [31:0] pwm_base_reg;
    logic        accept;
    logic        advance;

    // Handshake control
    assign advance         = hold_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall       = hold_valid_reg && !advance;
    assign accept          = req_valid && !req_stall;
    assign hold_valid_next = accept || (hold_valid_reg && !advance);
    assign out_valid_next  = advance || (out_valid_reg && rsp_stall);
    assign rsp_valid       = out_valid_reg;
    assign rsp_data        = out_reg;

    // Step logic
    pps_step u_step (
        .st        (state_reg),
        .item      (hold_reg),
        .pin_count (pin_count_reg),
        .pwm_base  (pwm_base_reg),
        .st_next   (state_next),
        .res       (res)
    );

    // Control and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= '{power_mode: MODE_POWERDOWN, default: '0};
            pin_count_reg  <= PIN_COUNT_RESET;
            pwm_base_reg   <= PWM_BASE_RESET;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_PIN_COUNT)
                begin
                    pin_count_reg <= cfg_data[2:0];
                end
                else
                begin
                    pwm_base_reg <= cfg_data;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_reg <= req_data;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    // A running sequence always has a delay pending
    a_run_delay: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.seq_running |-> state_reg.delay_left != 8'd0)
        else $error("sequence running with no delay pending");

    // Duty is nonzero only while unblanked
    a_duty_blank: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.duty != '0 |-> state_reg.power_mode == MODE_UNBLANK)
        else $error("duty set while blanked");

    // A busy rejection is reported only with a sequence running
    a_busy_stat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.status == STAT_BUSY |-> rsp_data.busy_res)
        else $error("busy status without running sequence");

    // Stored level never exceeds the limit
    a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.level <= MAX_LEVEL)
        else $error("brightness level above limit");

endmodule

`default_nettype wire

/* bench/tb_panel_power_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_panel_power_sequencer
// Self-checking bench for the LCD panel power sequencer.
// A queue-fed driver offers ticks, brightness and blank-mode requests. A
// model of the sequencer, kept in the bench, predicts one result per
// accepted request. A monitor compares every result field against the
// oldest prediction. Phases change the pin count and the PWM base word, and
// run with different amounts of sender idling and receiver stalling.
// ----------------------------------------------------------------------------

module tb_panel_power_sequencer
    import pps_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Action code that the block ignores
    localparam logic [1:0] ACT_NONE = 2'd3;

    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 6;

    // Bench copy of the sequencer state, plus the status of the last request
    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] lvl;
        logic [4:0] duty;
        logic [3:0] pins;
        logic [2:0] step;
        logic       on;
        logic       run;
        logic [7:0] dly;
        logic [1:0] latched;
        logic [1:0] stat;
    } panel_model_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    item_t       req_data = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    result_t     rsp_data;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_PIN_COUNT;
    logic [31:0] cfg_data = '0;

    panel_power_sequencer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Configuration as last written
    logic [2:0]   cfg_pins = PIN_COUNT_RESET;
    logic [31:0]  cfg_base = PWM_BASE_RESET;

    // Model advanced on accepted transfers, and one advanced as items are made
    panel_model_t panel_now;
    panel_model_t panel_gen;

    item_t        pending_items[$];
    result_t      expected_results[$];

    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  sender_hold = 1'b0;
    int  long_hold_reqs = 0;
    int  long_hold_served = 0;
    int  hold_cnt = 0;

    int  err_count = 0;
    int  items_sent = 0;
    int  results_seen = 0;
    int  seq_starts = 0;
    int  busy_rejects = 0;
    int  quiet_cycles = 0;
    result_t want;

    // ------------------------------------------------------------------------
    // Sequencer model
    // ------------------------------------------------------------------------
    function automatic panel_model_t model_reset();
        panel_model_t s;
        s = '0;
        s.mode = MODE_POWERDOWN;
        return s;
    endfunction

    function automatic logic [4:0] level_duty(logic [3:0] lvl);
        logic [5:0] p;
        p = {2'b00, lvl} * 6'd3;
        return p[4:0];
    endfunction

    // One pin change of the running sequence, then load the following delay
    function automatic panel_model_t fire_step(panel_model_t s);
        logic [3:0] mask;
        logic [7:0] gap;
        logic [1:0] grp;
        mask = '0;
        gap  = DLY_END;
        grp  = (s.latched > SEQ_4PIN) ? SEQ_4PIN : s.latched;
        case ({grp, s.on, s.step[1:0]})
            {SEQ_2PIN, 1'b0, 2'd0}: begin mask = PIN_BL;   gap = DLY_250; end
            {SEQ_2PIN, 1'b0, 2'd1}: begin mask = PIN_LCD;  gap = DLY_END; end
            {SEQ_2PIN, 1'b1, 2'd0}: begin mask = PIN_LCD;  gap = DLY_25;  end
            {SEQ_2PIN, 1'b1, 2'd1}: begin mask = PIN_BL;   gap = DLY_END; end
            {SEQ_3PIN, 1'b0, 2'd0}: begin mask = PIN_BL;   gap = DLY_250; end
            {SEQ_3PIN, 1'b0, 2'd1}: begin mask = PIN_VDD;  gap = DLY_25;  end
            {SEQ_3PIN, 1'b0, 2'd2}: begin mask = PIN_LCD;  gap = DLY_END; end
            {SEQ_3PIN, 1'b1, 2'd0}: begin mask = PIN_LCD;  gap = DLY_25;  end
            {SEQ_3PIN, 1'b1, 2'd1}: begin mask = PIN_VDD;  gap = DLY_250; end
            {SEQ_3PIN, 1'b1, 2'd2}: begin mask = PIN_BL;   gap = DLY_END; end
            {SEQ_4PIN, 1'b0, 2'd0}: begin mask = PIN_BL;   gap = DLY_25;  end
            {SEQ_4PIN, 1'b0, 2'd1}:
            begin
                mask = PIN_LCD | PIN_BIAS | PIN_VDD;
                gap  = DLY_END;
            end
            {SEQ_4PIN, 1'b1, 2'd0}: begin mask = PIN_LCD;  gap = DLY_50;  end
            {SEQ_4PIN, 1'b1, 2'd1}: begin mask = PIN_VDD;  gap = DLY_20;  end
            {SEQ_4PIN, 1'b1, 2'd2}: begin mask = PIN_BIAS; gap = DLY_250; end
            {SEQ_4PIN, 1'b1, 2'd3}: begin mask = PIN_BL;   gap = DLY_END; end
            default: ;
        endcase
        s.pins = s.on ? (s.pins | mask) : (s.pins & ~mask);
        s.dly  = gap;
        s.step = {1'b0, s.step[1:0]} + 3'd1;
        if (gap == DLY_END)
            s.run = 1'b0;
        return s;
    endfunction

    function automatic panel_model_t next_model(panel_model_t s, item_t it, logic [2:0] pcount);
        logic [3:0] req;
        logic [2:0] latch;
        s.stat = STAT_OK;
        case (it.action)
            ACT_TICK:
            begin
                if (s.run)
                begin
                    if (s.dly != '0)
                        s.dly = s.dly - 8'd1;
                    if (s.dly == '0)
                        s = fire_step(s);
                end
            end
            ACT_LEVEL:
            begin
                req = (it.brightness > MAX_LEVEL) ? MAX_LEVEL : it.brightness;
                if (req != s.lvl)
                begin
                    if (s.mode == MODE_UNBLANK)
                        s.duty = level_duty(req);
                    s.lvl = req;
                end
            end
            ACT_MODE:
            begin
                if (s.run)
                    s.stat = STAT_BUSY;
                else if (it.blank_mode <= MODE_LAST && it.blank_mode != s.mode)
                begin
                    s.mode = it.blank_mode;
                    s.duty = (it.blank_mode == MODE_UNBLANK) ? level_duty(s.lvl) : '0;
                    if (pcount >= PINS_MIN && pcount <= PINS_MAX)
                    begin
                        latch     = pcount - PINS_MIN;
                        s.latched = latch[1:0];
                        s.on      = (it.blank_mode == MODE_UNBLANK);
                        s.step    = '0;
                        s.run     = 1'b1;
                        s = fire_step(s);
                    end
                    else
                        s.stat = STAT_BAD_PINS;
                end
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic result_t result_of(panel_model_t s, logic [31:0] base);
        result_t r;
        r.pwm_word         = {base[31:5], s.duty};
        r.lcd_enable       = (s.pins & PIN_LCD) != '0;
        r.vdd_enable       = (s.pins & PIN_VDD) != '0;
        r.bias_enable      = (s.pins & PIN_BIAS) != '0;
        r.backlight_enable = (s.pins & PIN_BL) != '0;
        r.busy_res         = s.run;
        r.brightness_now   = s.lvl;
        r.status           = s.stat;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting
    // ------------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        err_count++;
        if (err_count <= 40)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task automatic check_field(string field, logic [31:0] got, logic [31:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s got %0h expected %0h", field, got, exp_val));
    endtask

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Driver: predicts on each request transfer, then offers the next item
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req_data  <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                panel_now = next_model(panel_now, req_data, cfg_pins);
                if (panel_now.stat == STAT_BUSY)
                    busy_rejects++;
                // a started sequence has just taken its first step
                if (panel_now.run && panel_now.step == 3'd1 && req_data.action == ACT_MODE
                    && panel_now.stat == STAT_OK)
                    seq_starts++;
                expected_results.push_back(result_of(panel_now, cfg_base));
                items_sent++;
            end
            // a stalled item stays in place
            if (!req_valid || !req_stall)
            begin
                if (pending_items.size() != 0 && !sender_hold
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    req_data  <= pending_items.pop_front();
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: result checks and receiver stalls
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result transfer with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    check_field("pwm_word", rsp_data.pwm_word, want.pwm_word);
                    check_field("lcd_enable", 32'(rsp_data.lcd_enable),
                                32'(want.lcd_enable));
                    check_field("vdd_enable", 32'(rsp_data.vdd_enable),
                                32'(want.vdd_enable));
                    check_field("bias_enable", 32'(rsp_data.bias_enable),
                                32'(want.bias_enable));
                    check_field("backlight_enable", 32'(rsp_data.backlight_enable),
                                32'(want.backlight_enable));
                    check_field("busy_res", 32'(rsp_data.busy_res), 32'(want.busy_res));
                    check_field("brightness_now", 32'(rsp_data.brightness_now),
                                32'(want.brightness_now));
                    check_field("status", 32'(rsp_data.status), 32'(want.status));
                end
                results_seen++;
            end
            // long hold-off on request, else random stalls
            if (long_hold_served != long_hold_reqs)
            begin
                long_hold_served = long_hold_reqs;
                hold_cnt = LONG_HOLD;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any transfer
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transfer for %0d cycles", quiet_cycles);
                $display("[panel_power_sequencer] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic push_item(logic [1:0] act, logic [3:0] br, logic [2:0] md);
        item_t it;
        it.action     = act;
        it.brightness = br;
        it.blank_mode = md;
        panel_gen = next_model(panel_gen, it, cfg_pins);
        pending_items.push_back(it);
    endtask

    // Mostly ticks while a sequence runs, mostly requests while idle
    task automatic add_random_item();
        int         r;
        logic [1:0] act;
        logic [2:0] md;
        r = $urandom_range(99);
        if (panel_gen.run)
            act = (r < 80) ? ACT_TICK : (r < 90) ? ACT_LEVEL : (r < 96) ? ACT_MODE : ACT_NONE;
        else
            act = (r < 35) ? ACT_MODE : (r < 60) ? ACT_LEVEL : (r < 90) ? ACT_TICK : ACT_NONE;
        if (act == ACT_MODE && $urandom_range(9) != 0)
            md = 3'($urandom_range(MODE_LAST));
        else
            md = 3'($urandom_range(7));
        push_item(act, 4'($urandom_range(15)), md);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || req_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_config(logic [2:0] pins, logic [31:0] base);
        logic [31:0] junk;
        junk = $urandom();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PIN_COUNT;
        cfg_data  <= {junk[31:3], pins};
        @(posedge clk);
        cfg_index <= CFG_PWM_BASE;
        cfg_data  <= base;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_pins = pins;
        cfg_base = base;
        @(negedge clk);
    endtask

    task automatic run_phase(logic [2:0] pins, logic [31:0] base, int send_pct,
                             int recv_pct, int count, bit long_stall, bit mid_pause);
        wait_drained();
        write_config(pins, base);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
        repeat (count) add_random_item();
        if (long_stall)
            long_hold_reqs++;
        if (mid_pause)
        begin
            while (pending_items.size() > count / 2)
                @(negedge clk);
            sender_hold = 1'b1;
            while (req_valid || expected_results.size() != 0)
                @(negedge clk);
            sender_hold = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin
        panel_now = model_reset();
        panel_gen = model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Invalid pin count: mode changes update the mode and duty only, no sequence
        wait_drained();
        write_config(3'd7, 32'hFFFF_FFFF);
        push_item(ACT_TICK, 4'd15, 3'd7);
        push_item(ACT_LEVEL, 4'd0, 3'd0);
        push_item(ACT_LEVEL, 4'd15, 3'd0);
        push_item(ACT_LEVEL, 4'd11, 3'd7);
        push_item(ACT_LEVEL, 4'd5, 3'd0);
        push_item(ACT_MODE, 4'd0, MODE_UNBLANK);
        push_item(ACT_LEVEL, 4'd10, 3'd0);
        push_item(ACT_MODE, 4'd9, MODE_UNBLANK);
        push_item(ACT_MODE, 4'd0, 3'd5);
        push_item(ACT_MODE, 4'd0, 3'd7);
        push_item(ACT_NONE, 4'd15, 3'd7);
        push_item(ACT_MODE, 4'd0, MODE_POWERDOWN);
        push_item(ACT_LEVEL, 4'd3, 3'd0);
        push_item(ACT_MODE, 4'd0, 3'd1);
        push_item(ACT_MODE, 4'd0, 3'd2);
        push_item(ACT_MODE, 4'd0, 3'd3);
        push_item(ACT_TICK, 4'd0, 3'd0);

        // Two-pin power on, requests while busy, then power off left running
        wait_drained();
        write_config(3'd2, 32'h0000_0000);
        push_item(ACT_MODE, 4'd0, MODE_UNBLANK);
        push_item(ACT_MODE, 4'd0, MODE_POWERDOWN);
        push_item(ACT_LEVEL, 4'd15, 3'd0);
        push_item(ACT_NONE, 4'd0, 3'd0);
        repeat (25) push_item(ACT_TICK, 4'd0, 3'd0);
        push_item(ACT_MODE, 4'd0, MODE_POWERDOWN);

        // Random phases; the first changes the pin count mid-sequence
        run_phase(3'd4, PWM_BASE_RESET, 0, 0, 300, 1'b1, 1'b0);
        run_phase(3'd3, $urandom(), 72, 0, 350, 1'b0, 1'b0);
        run_phase(3'd2, $urandom(), 0, 72, 350, 1'b0, 1'b1);
        run_phase(3'd5, 32'hFFFF_FFFF, 21, 21, 150, 1'b0, 1'b0);
        run_phase(3'd4, 32'h0000_0000, 21, 21, 400, 1'b0, 1'b0);
        run_phase(3'd0, $urandom(), 0, 0, 80, 1'b0, 1'b0);
        run_phase(3'd1, $urandom(), 72, 72, 60, 1'b0, 1'b0);
        run_phase(3'd3, $urandom(), 21, 21, 300, 1'b0, 1'b0);

        wait_drained();
        if (expected_results.size() != 0)
            report_mismatch("expected results left over");

        $display("covered %0d request transfers and %0d checked results", items_sent,
                 results_seen);
        $display("pin counts 0 to 5 and 7, %0d power sequences, %0d busy rejects",
                 seq_starts, busy_rejects);
        if (err_count == 0)
            $display("[panel_power_sequencer] OK");
        else
            $display("[panel_power_sequencer] ERROR");
        $finish;
    end

endmodule
